// ----- rtl/fmrb_pkg.sv -----
// ----------------------------------------------------------------------------
// fmrb_pkg
// Shared types and constants of the broadcast multi-reader ring buffer.
// ----------------------------------------------------------------------------
package fmrb_pkg;

  localparam int READERS_DEF    = 8;
  localparam int RING_DEPTH_DEF = 1024;
  localparam int MAX_CAPACITY   = 1 << 20;

  typedef enum logic [2:0] {
    OP_WRITE   = 3'd0,
    OP_READ    = 3'd1,
    OP_DISCARD = 3'd2,
    OP_CLAIM   = 3'd3,
    OP_RELEASE = 3'd4,
    OP_QUERY   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_RDY  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NO_FREE  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_CAP_LOG2 = 2'd0,
    REG_CHANNELS = 2'd1,
    REG_PROD_ACT = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WR_RD,
    S_WR_UPD,
    S_RD_WAIT,
    S_OUT
  } fsm_t;

endpackage

// ----- rtl/fanout_multi_reader_ring_buffer_top.sv -----
// ----------------------------------------------------------------------------
// fanout_multi_reader_ring_buffer_top
// One producer broadcasts frames into a private ring per claimed reader slot.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_ready   op, slot, samples, last, count
// out_      output     out_valid/out_ready status and result fields
// cfg_      input      APB write/read      three registers at 4*i
//
// A write word walks the slots one at a time through the slot state
// memory (read, then modify and write back). Reads, discards and queries
// wait on the registered slot state read; a read also waits on the
// registered frame store read. The frame store has no reset; slot state
// is cleared by a sweep of all slots after reset, with no word accepted.
// Words are accepted while a finished result waits only after it is taken.
// ----------------------------------------------------------------------------
module fanout_multi_reader_ring_buffer_top #(
  parameter int READERS    = fmrb_pkg::READERS_DEF,
  parameter int RING_DEPTH = fmrb_pkg::RING_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [2:0]  in_slot,
  input  logic [31:0] in_sample_left,
  input  logic [31:0] in_sample_right,
  input  logic        in_last_of_block,
  input  logic [10:0] in_frame_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [2:0]  out_slot_index,
  output logic [31:0] out_out_left,
  output logic [31:0] out_out_right,
  output logic [10:0] out_available_frames,
  output logic [31:0] out_dropped_total,
  output logic [31:0] out_overflow_count,
  output logic [3:0]  out_active_readers,
  output logic [3:0]  out_accepting_readers,
  output logic [10:0] out_frames_discarded,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int SW  = (READERS > 1) ? $clog2(READERS) : 1;
  localparam int RW  = $clog2(RING_DEPTH);
  localparam int PW  = RW + 1;
  localparam int AW  = SW + RW;
  localparam int CW  = $clog2(READERS + 1);
  // Slot state word: wp, rp, drop, epoch, loss.
  localparam int STW = 2 * PW + 65;

  // Configuration registers.
  logic [3:0] cap_log2_r;
  logic [1:0] chan_r;
  logic       prod_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_log2_r <= 4'd10;
      chan_r     <= 2'd2;
      prod_r     <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        fmrb_pkg::REG_CAP_LOG2: cap_log2_r <= cfg_pwdata[3:0];
        fmrb_pkg::REG_CHANNELS: chan_r     <= cfg_pwdata[1:0];
        fmrb_pkg::REG_PROD_ACT: prod_r     <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      fmrb_pkg::REG_CAP_LOG2: cfg_prdata = {28'd0, cap_log2_r};
      fmrb_pkg::REG_CHANNELS: cfg_prdata = {30'd0, chan_r};
      fmrb_pkg::REG_PROD_ACT: cfg_prdata = {31'd0, prod_r};
      default:                cfg_prdata = 32'd0;
    endcase
  end

  // Effective capacity, clamped to the ring depth.
  logic [PW-1:0] cap;
  logic [PW-1:0] cap_mask;
  logic          two_ch;
  always_comb begin
    logic [4:0] lg;
    lg = (cap_log2_r == 4'd0) ? 5'd1 : {1'b0, cap_log2_r};
    if (32'(lg) >= 32'(RW)) cap = PW'(RING_DEPTH);
    else cap = PW'(1) << lg;
    cap_mask = cap - PW'(1);
  end
  assign two_ch = chan_r[1];

  // Slot state memory and flags.
  logic [STW-1:0] st_mem [READERS];
  logic [STW-1:0] st_rd_r;
  logic [SW-1:0]  st_raddr;
  logic           st_we;
  logic [SW-1:0]  st_waddr;
  logic [STW-1:0] st_wdata;

  logic [63:0]    fs_mem [READERS * RING_DEPTH];
  logic [63:0]    fs_rd_r;
  logic           fs_we;
  logic [AW-1:0]  fs_waddr;
  logic [AW-1:0]  fs_raddr;
  logic [63:0]    fs_wdata;

  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_waddr] <= st_wdata;
    st_rd_r <= st_mem[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (fs_we) fs_mem[fs_waddr] <= fs_wdata;
    fs_rd_r <= fs_mem[fs_raddr];
  end

  logic [READERS-1:0] owned_r, owned_nxt;
  logic [READERS-1:0] acked_r, acked_nxt;

  // Control.
  fmrb_pkg::fsm_t state_r, state_nxt;
  logic          clr_r, clr_nxt;
  logic [SW:0]   clr_cnt_r, clr_cnt_nxt;
  logic [SW:0]   idx_r, idx_nxt;
  logic [2:0]    op_r;
  logic [2:0]    slot_r;
  logic [31:0]   left_r, right_r;
  logic          last_r;
  logic [10:0]   fcnt_r;
  logic [CW-1:0] act_r, act_nxt, accp_r, accp_nxt;

  // Result register.
  logic        ov_r, ov_nxt;
  logic [1:0]  o_st_r, o_st_nxt;
  logic [2:0]  o_si_r, o_si_nxt;
  logic [31:0] o_l_r, o_l_nxt, o_rt_r, o_rt_nxt;
  logic [10:0] o_av_r, o_av_nxt, o_dc_r, o_dc_nxt;
  logic [31:0] o_dr_r, o_dr_nxt, o_ep_r, o_ep_nxt;

  logic in_acc;
  assign in_ready = (state_r == fmrb_pkg::S_IDLE) && !clr_r && !ov_r;
  assign in_acc   = in_valid && in_ready;

  // Fields of the state word read back.
  logic [PW-1:0] s_wp, s_rp;
  logic [31:0]   s_dr, s_ep;
  logic          s_ls;
  assign {s_wp, s_rp, s_dr, s_ep, s_ls} = st_rd_r;

  logic [PW-1:0] used, fill;
  assign used = s_wp - s_rp;
  assign fill = (used <= cap) ? used : PW'(0);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= in_op;
      slot_r  <= in_slot;
      left_r  <= in_sample_left;
      right_r <= in_sample_right;
      last_r  <= in_last_of_block;
      fcnt_r  <= in_frame_count;
    end
  end

  always_comb begin
    logic [SW-1:0] ci;
    logic [PW-1:0] wp, rp, n;
    logic [31:0]   dr, ep;
    logic          ls;
    logic          own_i;
    ci = idx_r[SW-1:0];
    wp = s_wp; rp = s_rp; dr = s_dr; ep = s_ep; ls = s_ls; n = '0;
    own_i = 1'b0;
    state_nxt = state_r;
    clr_nxt = clr_r; clr_cnt_nxt = clr_cnt_r; idx_nxt = idx_r;
    act_nxt = act_r; accp_nxt = accp_r;
    owned_nxt = owned_r; acked_nxt = acked_r;
    ov_nxt = ov_r;
    o_st_nxt = o_st_r; o_si_nxt = o_si_r; o_l_nxt = o_l_r; o_rt_nxt = o_rt_r;
    o_av_nxt = o_av_r; o_dc_nxt = o_dc_r; o_dr_nxt = o_dr_r; o_ep_nxt = o_ep_r;
    st_raddr = slot_r[SW-1:0];
    st_we = 1'b0; st_waddr = ci; st_wdata = '0;
    fs_we = 1'b0; fs_waddr = '0; fs_wdata = '0;
    fs_raddr = {slot_r[SW-1:0], RW'(s_rp & cap_mask)};

    if (ov_r && out_ready) ov_nxt = 1'b0;

    if (clr_r) begin
      st_we = 1'b1;
      st_waddr = clr_cnt_r[SW-1:0];
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (32'(clr_cnt_r) == READERS - 1) clr_nxt = 1'b0;
    end

    case (state_r)
      fmrb_pkg::S_IDLE: begin
        if (in_acc) begin
          o_st_nxt = fmrb_pkg::ST_OK; o_si_nxt = '0; o_l_nxt = '0; o_rt_nxt = '0;
          o_av_nxt = '0; o_dc_nxt = '0; o_dr_nxt = '0; o_ep_nxt = '0;
          idx_nxt = '0; act_nxt = '0; accp_nxt = '0;
          st_raddr = in_slot[SW-1:0];
          case (in_op)
            fmrb_pkg::OP_WRITE: begin
              if (!prod_r) begin
                o_st_nxt = fmrb_pkg::ST_NOT_RDY; state_nxt = fmrb_pkg::S_OUT;
              end else begin
                st_raddr = '0; state_nxt = fmrb_pkg::S_WR_RD;
              end
            end
            fmrb_pkg::OP_READ, fmrb_pkg::OP_DISCARD, fmrb_pkg::OP_QUERY: begin
              if (!(prod_r && 32'(in_slot) < READERS && owned_r[in_slot[SW-1:0]]
                    && acked_r[in_slot[SW-1:0]])) begin
                o_st_nxt = fmrb_pkg::ST_NOT_RDY; state_nxt = fmrb_pkg::S_OUT;
              end else begin
                state_nxt = fmrb_pkg::S_WR_UPD;
              end
            end
            fmrb_pkg::OP_CLAIM: begin
              state_nxt = fmrb_pkg::S_OUT;
              if (!prod_r) o_st_nxt = fmrb_pkg::ST_NOT_RDY;
              else begin
                o_st_nxt = fmrb_pkg::ST_NO_FREE;
                for (int i = READERS - 1; i >= 0; i--) begin
                  if (!owned_r[i]) begin
                    o_st_nxt = fmrb_pkg::ST_OK; o_si_nxt = 3'(i);
                  end
                end
                if (o_st_nxt == fmrb_pkg::ST_OK) begin
                  owned_nxt[o_si_nxt[SW-1:0]] = 1'b1;
                  acked_nxt[o_si_nxt[SW-1:0]] = 1'b0;
                end
              end
            end
            fmrb_pkg::OP_RELEASE: begin
              state_nxt = fmrb_pkg::S_OUT;
              if (32'(in_slot) < READERS) begin
                owned_nxt[in_slot[SW-1:0]] = 1'b0;
                acked_nxt[in_slot[SW-1:0]] = 1'b0;
                // Clearing the note is folded into the reset at acknowledge.
              end
            end
            default: state_nxt = fmrb_pkg::S_OUT;
          endcase
        end
      end
      fmrb_pkg::S_WR_RD: begin
        // The state word of slot idx_r is on the read port; keep it there.
        st_raddr = idx_r[SW-1:0];
        state_nxt = (op_r == fmrb_pkg::OP_WRITE) ? fmrb_pkg::S_WR_UPD : fmrb_pkg::S_RD_WAIT;
      end
      fmrb_pkg::S_WR_UPD: begin
        if (op_r == fmrb_pkg::OP_WRITE) begin
          own_i = owned_r[ci];
          if (own_i) begin
            act_nxt = act_r + 1'b1;
            if (!acked_r[ci]) begin
              wp = '0; rp = '0; dr = '0; ep = '0; ls = 1'b0;
              acked_nxt[ci] = 1'b1;
            end
            n = wp - rp;
            if (n < cap) begin
              fs_we = 1'b1;
              fs_waddr = {ci, RW'(wp & cap_mask)};
              fs_wdata = {two_ch ? right_r : 32'd0, left_r};
              wp = wp + 1'b1;
              accp_nxt = accp_r + 1'b1;
            end else begin
              dr = dr + 1'b1; ls = 1'b1;
            end
            if (last_r && ls) begin
              ep = ep + 1'b1; ls = 1'b0;
            end
            st_we = 1'b1; st_waddr = ci; st_wdata = {wp, rp, dr, ep, ls};
          end
          if (32'(idx_r) == READERS - 1) begin
            o_st_nxt = fmrb_pkg::ST_OK;
            o_av_nxt = '0;
            o_dr_nxt = '0;
            state_nxt = fmrb_pkg::S_OUT;
          end else begin
            idx_nxt = idx_r + 1'b1;
            st_raddr = idx_nxt[SW-1:0];
            state_nxt = fmrb_pkg::S_WR_RD;
          end
        end else begin
          // Read, discard or query: state word of slot_r is valid.
          fs_raddr = {slot_r[SW-1:0], RW'(s_rp & cap_mask)};
          if (op_r == fmrb_pkg::OP_READ) begin
            if (fill == '0) begin
              o_st_nxt = fmrb_pkg::ST_EMPTY; rp = s_rp;
              state_nxt = fmrb_pkg::S_OUT;
            end else begin
              rp = s_rp + 1'b1;
              state_nxt = fmrb_pkg::S_RD_WAIT;
            end
          end else if (op_r == fmrb_pkg::OP_DISCARD) begin
            n = (32'(fcnt_r) < 32'(fill)) ? PW'(fcnt_r) : fill;
            rp = s_rp + n;
            o_dc_nxt = 11'(n);
            state_nxt = fmrb_pkg::S_OUT;
          end else begin
            state_nxt = fmrb_pkg::S_OUT;
          end
          if (o_st_nxt != fmrb_pkg::ST_EMPTY) begin
            st_we = 1'b1; st_waddr = slot_r[SW-1:0];
            st_wdata = {s_wp, rp, s_dr, s_ep, s_ls};
          end
          n = s_wp - rp;
          o_av_nxt = (n <= cap) ? 11'(n) : 11'd0;
          o_dr_nxt = s_dr; o_ep_nxt = s_ep;
        end
      end
      fmrb_pkg::S_RD_WAIT: begin
        o_l_nxt = fs_rd_r[31:0];
        o_rt_nxt = two_ch ? fs_rd_r[63:32] : 32'd0;
        state_nxt = fmrb_pkg::S_OUT;
      end
      fmrb_pkg::S_OUT: begin
        ov_nxt = 1'b1;
        state_nxt = fmrb_pkg::S_IDLE;
      end
      default: state_nxt = fmrb_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= fmrb_pkg::S_IDLE;
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
      owned_r   <= '0;
      acked_r   <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      owned_r   <= owned_nxt;
      acked_r   <= acked_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    act_r  <= act_nxt;
    accp_r <= accp_nxt;
    o_st_r <= o_st_nxt; o_si_r <= o_si_nxt; o_l_r <= o_l_nxt; o_rt_r <= o_rt_nxt;
    o_av_r <= o_av_nxt; o_dc_r <= o_dc_nxt; o_dr_r <= o_dr_nxt; o_ep_r <= o_ep_nxt;
  end

  logic is_wr_out;
  assign is_wr_out = (op_r == fmrb_pkg::OP_WRITE) && (o_st_r == fmrb_pkg::ST_OK);

  assign out_valid             = ov_r;
  assign out_status            = o_st_r;
  assign out_slot_index        = o_si_r;
  assign out_out_left          = o_l_r;
  assign out_out_right         = o_rt_r;
  assign out_available_frames  = o_av_r;
  assign out_dropped_total     = o_dr_r;
  assign out_overflow_count    = o_ep_r;
  assign out_active_readers    = is_wr_out ? 4'(act_r) : 4'd0;
  assign out_accepting_readers = is_wr_out ? 4'(accp_r) : 4'd0;
  assign out_frames_discarded  = o_dc_r;

`ifndef NO_ASSERTIONS
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !in_ready) else $error("word accepted during clearing sweep");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ready |=> ov_r && $stable(o_st_r)) else $error("result lost");
  a_accp_le_act: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> accp_r <= act_r) else $error("more accepting than active slots");
  a_acked_owned: assert property (@(posedge clk) disable iff (!rst_n)
    (acked_r & ~owned_r) == '0) else $error("acknowledged slot not owned");
`endif

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Broadcast multi-reader ring buffer testbench
// Drives words into the block under several register settings and idling
// phases, predicts every result with an independent model of the slot rings,
// and compares each whole result word in order.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [1:0]  status;
  logic [2:0]  slot_index;
  logic [31:0] left;
  logic [31:0] right;
  logic [10:0] avail;
  logic [31:0] dropped;
  logic [31:0] overflows;
  logic [3:0]  active;
  logic [3:0]  accepting;
  logic [10:0] discarded;
} ring_result_t;

class ring_scoreboard;
  bit [63:0]    frames [int];
  logic [10:0]  wr_ptr [8];
  logic [10:0]  rd_ptr [8];
  logic [31:0]  drops [8];
  logic [31:0]  epochs [8];
  bit           owned [8];
  bit           acked [8];
  bit           loss [8];
  int           cap_lg = 10;
  int           chans = 2;
  bit           producer = 0;
  ring_result_t pending [$];
  int           errors = 0;

  function new();
    for (int i = 0; i < 8; i++) begin
      wr_ptr[i] = '0; rd_ptr[i] = '0; drops[i] = '0; epochs[i] = '0;
      owned[i] = 0; acked[i] = 0; loss[i] = 0;
    end
  endfunction

  function void set_reg(fmrb_pkg::reg_idx_t idx, logic [31:0] val);
    case (idx)
      fmrb_pkg::REG_CAP_LOG2: cap_lg = val[3:0];
      fmrb_pkg::REG_CHANNELS: chans = val[1:0];
      fmrb_pkg::REG_PROD_ACT: producer = val[0];
      default: ;
    endcase
  endfunction

  function int capacity();
    int lg;
    int c;
    lg = (cap_lg < 1) ? 1 : cap_lg;
    c = 1 << lg;
    if (c > 1024) c = 1024;
    return c;
  endfunction

  function int fill(int s, int cap);
    logic [10:0] used;
    used = wr_ptr[s] - rd_ptr[s];
    return (used <= cap) ? used : 0;
  endfunction

  function void note_word(logic [2:0] op, logic [2:0] s, logic [31:0] l, logic [31:0] r,
                          bit last, logic [10:0] fc);
    ring_result_t res;
    int cap;
    int act;
    int acc;
    int avail;
    int n;
    logic [10:0] used;
    res = '0;
    cap = capacity();
    case (op)
      fmrb_pkg::OP_WRITE: begin
        if (!producer) res.status = fmrb_pkg::ST_NOT_RDY;
        else begin
          act = 0; acc = 0;
          for (int i = 0; i < 8; i++) begin
            if (!owned[i]) continue;
            act++;
            if (!acked[i]) begin
              wr_ptr[i] = '0; rd_ptr[i] = '0; drops[i] = '0; epochs[i] = '0;
              loss[i] = 0; acked[i] = 1;
            end
            used = wr_ptr[i] - rd_ptr[i];
            if (used < cap) begin
              frames[i * 1024 + (wr_ptr[i] & (cap - 1))] =
                {(chans >= 2) ? r : 32'd0, l};
              wr_ptr[i] = 11'(wr_ptr[i] + 1);
              acc++;
            end else begin
              drops[i] = 32'(drops[i] + 1);
              loss[i] = 1;
            end
            if (last && loss[i]) begin
              epochs[i] = 32'(epochs[i] + 1);
              loss[i] = 0;
            end
          end
          res.active = 4'(act);
          res.accepting = 4'(acc);
        end
      end
      fmrb_pkg::OP_READ, fmrb_pkg::OP_DISCARD, fmrb_pkg::OP_QUERY: begin
        if (!(producer && owned[s] && acked[s])) res.status = fmrb_pkg::ST_NOT_RDY;
        else begin
          avail = fill(s, cap);
          if (op == fmrb_pkg::OP_READ) begin
            if (avail == 0) res.status = fmrb_pkg::ST_EMPTY;
            else begin
              res.left = frames[s * 1024 + (rd_ptr[s] & (cap - 1))][31:0];
              res.right = (chans >= 2) ? frames[s * 1024 + (rd_ptr[s] & (cap - 1))][63:32]
                                       : 32'd0;
              rd_ptr[s] = 11'(rd_ptr[s] + 1);
            end
          end else if (op == fmrb_pkg::OP_DISCARD) begin
            n = (fc < avail) ? fc : avail;
            rd_ptr[s] = 11'(rd_ptr[s] + n);
            res.discarded = 11'(n);
          end
          res.avail = 11'(fill(s, cap));
          res.dropped = drops[s];
          res.overflows = epochs[s];
        end
      end
      fmrb_pkg::OP_CLAIM: begin
        if (!producer) res.status = fmrb_pkg::ST_NOT_RDY;
        else begin
          res.status = fmrb_pkg::ST_NO_FREE;
          for (int i = 0; i < 8; i++) begin
            if (!owned[i]) begin
              owned[i] = 1; acked[i] = 0;
              res.status = fmrb_pkg::ST_OK; res.slot_index = 3'(i);
              break;
            end
          end
        end
      end
      fmrb_pkg::OP_RELEASE: begin
        owned[s] = 0; acked[s] = 0; loss[s] = 0;
      end
      default: ;
    endcase
    pending.push_back(res);
  endfunction

  function void check_word(ring_result_t got);
    ring_result_t want;
    if (pending.size() == 0) begin
      errors++;
      $display("%0t: unexpected result word, actual %p", $time, got);
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      errors++;
      $display("%0t: mismatch expected %p actual %p", $time, want, got);
    end
  endfunction
endclass

module tb;
  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [2:0]  in_op = 0;
  logic [2:0]  in_slot = 0;
  logic [31:0] in_sample_left = 0;
  logic [31:0] in_sample_right = 0;
  logic        in_last_of_block = 0;
  logic [10:0] in_frame_count = 0;
  logic        out_valid;
  logic        out_ready = 0;
  ring_result_t got;
  logic        cfg_psel = 0;
  logic        cfg_penable = 0;
  logic        cfg_pwrite = 0;
  logic [3:0]  cfg_paddr = 0;
  logic [31:0] cfg_pwdata = 0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  ring_scoreboard rings = new();
  int idle_mode = 0;
  int cycles = 0;

  fanout_multi_reader_ring_buffer_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_op(in_op), .in_slot(in_slot),
    .in_sample_left(in_sample_left), .in_sample_right(in_sample_right),
    .in_last_of_block(in_last_of_block), .in_frame_count(in_frame_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(got.status), .out_slot_index(got.slot_index),
    .out_out_left(got.left), .out_out_right(got.right),
    .out_available_frames(got.avail), .out_dropped_total(got.dropped),
    .out_overflow_count(got.overflows), .out_active_readers(got.active),
    .out_accepting_readers(got.accepting), .out_frames_discarded(got.discarded),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata), .cfg_pready(cfg_pready)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Result side: check accepted words, then pick the next stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) rings.check_word(got);
    if (!rst_n) out_ready <= 0;
    else if (idle_mode == 2) out_ready <= ($urandom_range(0, 99) >= 45);
    else if (idle_mode == 3) out_ready <= ($urandom_range(0, 99) >= 19);
    else out_ready <= 1;
  end

  task automatic send_word(logic [2:0] op, logic [2:0] s, logic [31:0] l, logic [31:0] r,
                           bit last, logic [10:0] fc);
    int pct;
    pct = (idle_mode == 1) ? 45 : (idle_mode == 3) ? 19 : 0;
    if (pct > 0 && $urandom_range(0, 99) < pct) begin
      in_valid <= 0;
      do @(posedge clk); while ($urandom_range(0, 99) < pct);
    end
    in_valid <= 1;
    in_op <= op;
    in_slot <= s;
    in_sample_left <= l;
    in_sample_right <= r;
    in_last_of_block <= last;
    in_frame_count <= fc;
    do @(posedge clk); while (!in_ready);
    rings.note_word(op, s, l, r, last, fc);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (rings.pending.size() != 0) @(posedge clk);
    // A write word has finished sweeping the slots before its result leaves.
    repeat (40) @(posedge clk);
  endtask

  task automatic cfg_write(fmrb_pkg::reg_idx_t idx, logic [31:0] val);
    cfg_psel <= 1;
    cfg_penable <= 0;
    cfg_pwrite <= 1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    rings.set_reg(idx, val);
    @(posedge clk);
  endtask

  function automatic logic [2:0] pick_slot();
    int owned_list [$];
    for (int i = 0; i < 8; i++) if (rings.owned[i]) owned_list.push_back(i);
    if (owned_list.size() == 0 || $urandom_range(0, 99) < 15) return 3'($urandom_range(0, 7));
    return 3'(owned_list[$urandom_range(0, owned_list.size() - 1)]);
  endfunction

  // Rings are emptied before any setting changes, so no read ever reaches a
  // store entry written under another capacity.
  task automatic run_phase(int cap, int ch, int act, int mode, int n_words);
    int done;
    int pick;
    int len;
    drain();
    for (int i = 0; i < 8; i++) send_word(fmrb_pkg::OP_RELEASE, 3'(i), 0, 0, 0, 0);
    drain();
    cfg_write(fmrb_pkg::REG_CAP_LOG2, cap);
    cfg_write(fmrb_pkg::REG_CHANNELS, ch);
    cfg_write(fmrb_pkg::REG_PROD_ACT, act);
    idle_mode = mode;
    repeat ($urandom_range(1, 6)) send_word(fmrb_pkg::OP_CLAIM, 0, 0, 0, 0, 0);
    done = 0;
    while (done < n_words) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++)
          send_word(fmrb_pkg::OP_WRITE, 3'($urandom), $urandom, $urandom, k == len - 1,
                    11'($urandom));
        done += len;
      end else begin
        if (pick < 60)
          send_word(fmrb_pkg::OP_READ, pick_slot(), $urandom, $urandom, 1'($urandom),
                    11'($urandom));
        else if (pick < 70)
          send_word(fmrb_pkg::OP_DISCARD, pick_slot(), 0, 0, 0,
                    ($urandom_range(0, 19) == 0) ? 11'd1024 : 11'($urandom_range(0, 5)));
        else if (pick < 80) send_word(fmrb_pkg::OP_QUERY, pick_slot(), 0, 0, 0, 0);
        else if (pick < 87) send_word(fmrb_pkg::OP_CLAIM, 3'($urandom), 0, 0, 0, 0);
        else if (pick < 92) send_word(fmrb_pkg::OP_RELEASE, pick_slot(), 0, 0, 0, 0);
        else if (pick < 95) send_word(3'($urandom_range(6, 7)), 3'($urandom), $urandom,
                                      $urandom, 1'($urandom), 11'($urandom));
        else send_word(fmrb_pkg::OP_QUERY, 3'($urandom), 0, 0, 0, 0);
        done++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1;
    repeat (20) @(posedge clk);

    // Producer inactive: writes, claims and queries are refused.
    send_word(fmrb_pkg::OP_WRITE, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 11'd2047);
    send_word(fmrb_pkg::OP_CLAIM, 0, 0, 0, 0, 0);
    send_word(fmrb_pkg::OP_QUERY, 0, 0, 0, 0, 0);
    send_word(3'd6, 3'd7, 0, 0, 0, 0);
    send_word(3'd7, 0, 0, 0, 0, 0);
    send_word(fmrb_pkg::OP_RELEASE, 3'd5, 0, 0, 0, 0);
    drain();
    cfg_write(fmrb_pkg::REG_CAP_LOG2, 1);
    cfg_write(fmrb_pkg::REG_CHANNELS, 1);
    cfg_write(fmrb_pkg::REG_PROD_ACT, 1);
    repeat (9) send_word(fmrb_pkg::OP_CLAIM, 0, 0, 0, 0, 0);
    send_word(fmrb_pkg::OP_QUERY, 0, 0, 0, 0, 0);
    send_word(fmrb_pkg::OP_WRITE, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
    send_word(fmrb_pkg::OP_WRITE, 0, 32'h0, 32'h0, 0, 0);
    send_word(fmrb_pkg::OP_WRITE, 0, 32'h1234_5678, 32'h9ABC_DEF0, 0, 0);
    send_word(fmrb_pkg::OP_WRITE, 0, 32'h5555_AAAA, 32'hAAAA_5555, 1, 0);
    send_word(fmrb_pkg::OP_READ, 0, 0, 0, 0, 0);
    send_word(fmrb_pkg::OP_QUERY, 0, 0, 0, 0, 0);
    send_word(fmrb_pkg::OP_READ, 0, 0, 0, 0, 0);
    send_word(fmrb_pkg::OP_READ, 0, 0, 0, 0, 0);
    send_word(fmrb_pkg::OP_DISCARD, 3'd1, 0, 0, 0, 11'd1024);
    send_word(fmrb_pkg::OP_DISCARD, 3'd2, 0, 0, 0, 0);
    send_word(fmrb_pkg::OP_RELEASE, 3'd3, 0, 0, 0, 0);
    send_word(fmrb_pkg::OP_QUERY, 3'd3, 0, 0, 0, 0);
    send_word(fmrb_pkg::OP_CLAIM, 0, 0, 0, 0, 0);

    run_phase(2, 2, 1, 0, 150);
    run_phase(1, 1, 1, 1, 150);
    run_phase(3, 3, 1, 2, 150);
    run_phase(10, 0, 1, 3, 150);
    run_phase(0, 2, 1, 1, 120);
    run_phase(15, 2, 0, 0, 30);
    run_phase(4, 2, 1, 3, 170);

    drain();
    if (rings.errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end
endmodule
